/* hw/rtl/fces_pkg.sv */
// Shared constants, codes and control types of the coalescing event mailbox.
package fces_pkg;

   // Storage dimensions
   localparam int FIFO_DEPTH = 16;
   localparam int SLOT_COUNT = 64;
   localparam int DATA_WIDTH = 64;

   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Port field widths
   localparam int CMD_W    = 2;
   localparam int TYPE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int SLOT_W   = 6;
   localparam int PAYLD_W  = 64;
   localparam int STATUS_W = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DELIVERED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_REJECTED  = 3'd4;

   // Reserved type code of synthetic events
   localparam logic [TYPE_W-1:0] SYNTH_TYPE = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_full;
   } dp_status_type;

endpackage

/* hw/rtl/fifo_with_coalescing_event_slots_top.sv */
// Top level of the message mailbox with coalescing event slots.
//
// Mailbox with two sources. A push (cmd 0) appends an ordinary message (type,
// word, data) to a 16-entry FIFO; it answers fifo-full when the FIFO holds 16
// messages and rejected when the type is the reserved synthetic code 255. A
// post (cmd 1) sets the pending bit of one of 64 event slots and overwrites the
// slot data, so repeated posts to one slot coalesce into a single event. A poll
// (cmd 2) returns the FIFO head first, else the lowest-numbered pending slot
// (type 255, word = slot number) and clears that slot, else empty. Command 3
// is rejected. Every request transaction yields exactly one response
// transaction; result fields other than status read zero unless a message is
// delivered. A transaction passes through three steps: capture, execute
// (FIFO/slot memory access and lowest-pending-slot encode), then publish into
// the response register. The next request is taken in the cycle after publish,
// so no new request is taken while one is in progress, and publish waits while
// rsp_stall holds a finished response in the output register.
// No clearing pass is needed after reset.
module fifo_with_coalescing_event_slots_top
   import fces_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TYPE_W-1:0]   req_msg_type,
   input  logic [WORD_W-1:0]   req_msg_word,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  logic [PAYLD_W-1:0]  req_msg_data,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_out_synthetic,
   output logic [TYPE_W-1:0]   rsp_out_type,
   output logic [WORD_W-1:0]   rsp_out_word,
   output logic [PAYLD_W-1:0]  rsp_out_data
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequence each transaction through capture, execute and publish
   fces_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Hold the FIFO, the event slots and the response register
   fces_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status),
      .req_cmd           (req_cmd),
      .req_msg_type      (req_msg_type),
      .req_msg_word      (req_msg_word),
      .req_slot_index    (req_slot_index),
      .req_msg_data      (req_msg_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_synthetic (rsp_out_synthetic),
      .rsp_out_type      (rsp_out_type),
      .rsp_out_word      (rsp_out_word),
      .rsp_out_data      (rsp_out_data)
   );

endmodule

/* hw/rtl/fces_ctrl.sv */
// Sequencer of the mailbox: accept, execute, publish.
module fces_ctrl
   import fces_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   state_type state_ff;
   state_type state_in;
   logic      out_free;

   assign out_free = !dp_status.rsp_full || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall        = 1'b1;
      ctrl_cmd.capture = 1'b0;
      ctrl_cmd.execute = 1'b0;
      ctrl_cmd.publish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            ctrl_cmd.capture = req_valid;
         end
         ST_EXEC: begin
            ctrl_cmd.execute = 1'b1;
         end
         ST_PUBLISH: begin
            ctrl_cmd.publish = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* hw/rtl/fces_datapath.sv */
// Mailbox storage: message FIFO, event slots, pending mask and response register.
module fces_datapath
   import fces_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         ctrl_cmd,
   output dp_status_type        dp_status,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [TYPE_W-1:0]    req_msg_type,
   input  logic [WORD_W-1:0]    req_msg_word,
   input  logic [SLOT_W-1:0]    req_slot_index,
   input  logic [PAYLD_W-1:0]   req_msg_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_out_synthetic,
   output logic [TYPE_W-1:0]    rsp_out_type,
   output logic [WORD_W-1:0]    rsp_out_word,
   output logic [PAYLD_W-1:0]   rsp_out_data
);

   // Captured transaction
   logic [CMD_W-1:0]      cmd_ff;
   logic [TYPE_W-1:0]     type_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [DATA_WIDTH-1:0] data_ff;

   // Memories
   logic [TYPE_W-1:0]     queue_type_mem    [FIFO_DEPTH];
   logic [WORD_W-1:0]     queue_word_mem    [FIFO_DEPTH];
   logic [DATA_WIDTH-1:0] queue_payload_mem [FIFO_DEPTH];
   logic [DATA_WIDTH-1:0] slot_payload_mem  [SLOT_COUNT];

   logic [TYPE_W-1:0]     fifo_rd_type_ff;
   logic [WORD_W-1:0]     fifo_rd_word_ff;
   logic [DATA_WIDTH-1:0] fifo_rd_data_ff;
   logic [DATA_WIDTH-1:0] slot_rd_data_ff;

   // FIFO control and event mask
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_COUNT-1:0] pending_ff, pending_in;

   // Result of the execute step
   logic [STATUS_W-1:0]   res_status_ff;
   logic                  res_synth_ff;
   logic [SLOT_IDX_W-1:0] res_slot_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_synth_ff;
   logic [TYPE_W-1:0]     rsp_type_ff;
   logic [WORD_W-1:0]     rsp_word_ff;
   logic [PAYLD_W-1:0]    rsp_data_ff;

   // Decode
   logic                  fifo_full;
   logic                  slot_ok;
   logic                  do_push;
   logic                  do_post;
   logic                  do_pop;
   logic                  do_take_slot;
   logic [STATUS_W-1:0]   exec_status;
   logic [SLOT_IDX_W-1:0] post_idx;
   logic [SLOT_COUNT-1:0] lowest_onehot;
   logic [SLOT_IDX_W-1:0] win_idx;

   assign fifo_full = (count_ff == CNT_W'(FIFO_DEPTH));
   assign slot_ok   = ({1'b0, slot_ff} < (SLOT_W + 1)'(SLOT_COUNT));
   assign post_idx  = slot_ff[SLOT_IDX_W-1:0];

   // Isolate the lowest pending slot and encode its number
   assign lowest_onehot = pending_ff & (~pending_ff + SLOT_COUNT'(1));

   always_comb begin
      win_idx = '0;
      for (int b = 0; b < SLOT_IDX_W; b++) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (((i >> b) & 1) != 0) win_idx[b] = win_idx[b] | lowest_onehot[i];
         end
      end
   end

   always_comb begin
      do_push      = 1'b0;
      do_post      = 1'b0;
      do_pop       = 1'b0;
      do_take_slot = 1'b0;
      exec_status  = STAT_REJECTED;
      case (cmd_ff)
         CMD_PUSH: begin
            if (type_ff == SYNTH_TYPE) begin
               exec_status = STAT_REJECTED;
            end else if (fifo_full) begin
               exec_status = STAT_FULL;
            end else begin
               exec_status = STAT_ACCEPTED;
               do_push     = 1'b1;
            end
         end
         CMD_POST: begin
            if (slot_ok) begin
               exec_status = STAT_ACCEPTED;
               do_post     = 1'b1;
            end
         end
         CMD_POLL: begin
            if (count_ff != '0) begin
               exec_status = STAT_DELIVERED;
               do_pop      = 1'b1;
            end else if (pending_ff != '0) begin
               exec_status  = STAT_DELIVERED;
               do_take_slot = 1'b1;
            end else begin
               exec_status = STAT_EMPTY;
            end
         end
         default: begin
            exec_status = STAT_REJECTED;
         end
      endcase
   end

   // Pointer, count and mask updates
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (ctrl_cmd.execute) begin
         if (do_push) begin
            tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
            count_in = count_ff + CNT_W'(1);
         end
         if (do_pop) begin
            head_in  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
            count_in = count_ff - CNT_W'(1);
         end
         if (do_post) pending_in = pending_ff | (SLOT_COUNT'(1) << post_idx);
         if (do_take_slot) pending_in = pending_ff & ~lowest_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff  <= req_cmd;
         type_ff <= req_msg_type;
         word_ff <= req_msg_word;
         slot_ff <= req_slot_index;
         data_ff <= req_msg_data[DATA_WIDTH-1:0];
      end
   end

   // FIFO memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute && do_push) begin
         queue_type_mem[tail_ff]    <= type_ff;
         queue_word_mem[tail_ff]    <= word_ff;
         queue_payload_mem[tail_ff] <= data_ff;
      end
      if (ctrl_cmd.execute && do_pop) begin
         fifo_rd_type_ff <= queue_type_mem[head_ff];
         fifo_rd_word_ff <= queue_word_mem[head_ff];
         fifo_rd_data_ff <= queue_payload_mem[head_ff];
      end
   end

   // Slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute && do_post) begin
         slot_payload_mem[post_idx] <= data_ff;
      end
      if (ctrl_cmd.execute && do_take_slot) begin
         slot_rd_data_ff <= slot_payload_mem[win_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute) begin
         res_status_ff <= exec_status;
         res_synth_ff  <= do_take_slot;
         res_slot_ff   <= win_idx;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (ctrl_cmd.publish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_synth_ff  <= 1'b0;
         rsp_type_ff   <= '0;
         rsp_word_ff   <= '0;
         rsp_data_ff   <= '0;
         if (res_status_ff == STAT_DELIVERED) begin
            if (res_synth_ff) begin
               rsp_synth_ff <= 1'b1;
               rsp_type_ff  <= SYNTH_TYPE;
               rsp_word_ff  <= WORD_W'(res_slot_ff);
               rsp_data_ff  <= PAYLD_W'(slot_rd_data_ff);
            end else begin
               rsp_type_ff <= fifo_rd_type_ff;
               rsp_word_ff <= fifo_rd_word_ff;
               rsp_data_ff <= PAYLD_W'(fifo_rd_data_ff);
            end
         end
      end
   end

   assign dp_status.rsp_full = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_synthetic  = rsp_synth_ff;
   assign rsp_out_type       = rsp_type_ff;
   assign rsp_out_word       = rsp_word_ff;
   assign rsp_out_data       = rsp_data_ff;

   // Checks
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.publish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while still waiting");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fifo count beyond depth");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !ctrl_cmd.execute |=> $stable(count_ff) && $stable(pending_ff))
      else $error("mailbox state changed outside execute");

   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty fifo with unequal pointers");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.execute && do_take_slot) |=> !pending_ff[res_slot_ff])
      else $error("delivered slot still pending");

endmodule
